@@ hw/rtl/cdf_pkg.sv @@
package cdf_pkg;

  localparam int unsigned KEY_LEN = 15;
  localparam int unsigned CFG_W = 32;

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
  };

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_KEY    = 2'd0,
    PH_BLANK  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    END_IDLE   = 2'd0,
    END_CR     = 2'd1,
    END_CRLF   = 2'd2,
    END_CRLFCR = 2'd3
  } end_state_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload_byte;
    logic       last_byte;
  } res_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (32'(idx) < KEY_LEN) begin
      c = KEY_TEXT[idx];
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/cdf_if.sv @@
interface cdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface cdf_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output kind, output payload_byte, output last_byte,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input last_byte,
                output ready);
endinterface

interface cdf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cdf_pkg::CFG_W-1:0]  max_length;

  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

@@ hw/rtl/content_length_stream_deframer_core.sv @@
// Content-Length stream deframer.
// in_i carries one raw stream byte per transaction. While in the header the
// block looks for the first "Content-Length:" key, reads the decimal length
// after optional blanks and waits for CR LF CR LF. The following bytes of the
// message then leave on out_o as payload results, the final one flagged by
// last_byte. A zero length yields one empty-message result, any unusable
// header one header-discarded result; other header bytes give no result.
// cfg_i writes max_length, the largest length accepted, and is always ready.
// A byte is accepted into the input register, passes the parser step, and its
// result is then held in the result register that drives out_o.
// Throughput: one byte per cycle while out_o is not stalled, set by the combinational
// parser step between the input register and the result register.
// When out_o is stalled the result register holds, one more byte waits in the
// input register and in_i then drops ready until the result is taken.
// Reset returns the parser to header mode with no partial match and sets
// max_length to all ones.
module content_length_stream_deframer_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cdf_byte_if.sink             in_i,
  cdf_result_if.source         out_o,
  cdf_cfg_if.sink              cfg_i
);

  logic          stage_valid;
  logic [7:0]    stage_byte;
  logic          take;
  cdf_pkg::res_t res;

  assign cfg_i.ready = 1'b1;

  cdf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.stream_byte),
    .in_ready_o (in_i.ready),
    .take_i     (take),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  cdf_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.max_length),
    .step_i      (take),
    .byte_i      (stage_byte),
    .res_o       (res)
  );

  cdf_out_stage u_out_stage (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .stage_valid_i      (stage_valid),
    .res_i              (res),
    .out_ready_i        (out_o.ready),
    .take_o             (take),
    .out_valid_o        (out_o.valid),
    .out_kind_o         (out_o.kind),
    .out_payload_byte_o (out_o.payload_byte),
    .out_last_byte_o    (out_o.last_byte)
  );

endmodule

@@ hw/rtl/cdf_in_stage.sv @@
module cdf_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The stage refills in the same cycle that its byte moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ hw/rtl/cdf_parser.sv @@
module cdf_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [cdf_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       step_i,
  input  logic [7:0]                 byte_i,
  output cdf_pkg::res_t              res_o
);

  localparam int unsigned PROD_W = LENGTH_BITS + 4;
  localparam int unsigned CMP_W  = (LENGTH_BITS > cdf_pkg::CFG_W) ? LENGTH_BITS
                                                                   : cdf_pkg::CFG_W;

  logic                         in_payload_q, in_payload_d;
  logic [3:0]                   key_cnt_q, key_cnt_d;
  cdf_pkg::end_state_e          end_q, end_d;
  cdf_pkg::phase_e              phase_q, phase_d;
  logic                         seen_q, seen_d;
  logic [LENGTH_BITS-1:0]       len_q, len_d;
  logic                         over_q, over_d;
  logic [LENGTH_BITS-1:0]       rem_q, rem_d;
  logic [cdf_pkg::CFG_W-1:0]    max_len_q;

  logic [LENGTH_BITS-1:0]       rem_dec;
  logic [3:0]                   key_next;
  logic                         is_digit;
  logic                         is_blank;
  logic [3:0]                   digit_val;
  logic [7:0]                   digit_diff;
  logic [PROD_W-1:0]            len_wide;
  logic [PROD_W-1:0]            prod;
  logic                         term;

  assign is_digit   = (byte_i >= cdf_pkg::CHAR_ZERO) && (byte_i <= cdf_pkg::CHAR_NINE);
  assign is_blank   = (byte_i == cdf_pkg::CHAR_SPACE) || (byte_i == cdf_pkg::CHAR_TAB);
  assign digit_diff = byte_i - cdf_pkg::CHAR_ZERO;
  assign digit_val  = digit_diff[3:0];
  assign len_wide   = PROD_W'(len_q);
  // Times ten as two shifted terms; any bit above the length width means overflow.
  assign prod       = (len_wide << 3) + (len_wide << 1) + PROD_W'(digit_val);
  assign rem_dec    = rem_q - LENGTH_BITS'(1);

  always_comb begin
    in_payload_d = in_payload_q;
    key_cnt_d    = key_cnt_q;
    end_d        = end_q;
    phase_d      = phase_q;
    seen_d       = seen_q;
    len_d        = len_q;
    over_d       = over_q;
    rem_d        = rem_q;
    key_next     = 4'd0;
    term         = 1'b0;

    res_o.valid        = 1'b0;
    res_o.kind         = cdf_pkg::KIND_PAYLOAD;
    res_o.payload_byte = 8'h00;
    res_o.last_byte    = 1'b0;

    if (in_payload_q) begin
      rem_d              = rem_dec;
      res_o.valid        = 1'b1;
      res_o.payload_byte = byte_i;
      res_o.last_byte    = (rem_dec == '0);
      in_payload_d       = (rem_dec != '0);
    end else begin
      case (phase_q)
        cdf_pkg::PH_KEY: begin
          if (byte_i == cdf_pkg::key_char(key_cnt_q)) begin
            key_next = key_cnt_q + 4'd1;
          end else if (byte_i == cdf_pkg::KEY_TEXT[0]) begin
            key_next = 4'd1;
          end else begin
            key_next = 4'd0;
          end
          if (32'(key_next) >= cdf_pkg::KEY_LEN) begin
            phase_d   = cdf_pkg::PH_BLANK;
            key_cnt_d = 4'd0;
          end else begin
            key_cnt_d = key_next;
          end
        end
        cdf_pkg::PH_BLANK, cdf_pkg::PH_DIGITS: begin
          if (phase_q == cdf_pkg::PH_BLANK && is_blank) begin
            phase_d = phase_q;
          end else if (is_digit) begin
            phase_d = cdf_pkg::PH_DIGITS;
            seen_d  = 1'b1;
            if (!over_q) begin
              if (prod[PROD_W-1:LENGTH_BITS] != 4'd0) begin
                over_d = 1'b1;
              end else begin
                len_d = prod[LENGTH_BITS-1:0];
              end
            end
          end else begin
            phase_d = cdf_pkg::PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (byte_i == cdf_pkg::CHAR_CR) begin
        end_d = (end_q == cdf_pkg::END_CRLF) ? cdf_pkg::END_CRLFCR : cdf_pkg::END_CR;
      end else if (byte_i == cdf_pkg::CHAR_LF &&
                   (end_q == cdf_pkg::END_CR || end_q == cdf_pkg::END_CRLFCR)) begin
        if (end_q == cdf_pkg::END_CRLFCR) begin
          term  = 1'b1;
          end_d = cdf_pkg::END_IDLE;
        end else begin
          end_d = cdf_pkg::END_CRLF;
        end
      end else begin
        end_d = cdf_pkg::END_IDLE;
      end

      if (term) begin
        if (seen_d && !over_d && (CMP_W'(len_d) <= CMP_W'(max_len_q))) begin
          if (len_d == '0) begin
            res_o.valid = 1'b1;
            res_o.kind  = cdf_pkg::KIND_EMPTY;
          end else begin
            in_payload_d = 1'b1;
            rem_d        = len_d;
          end
        end else begin
          res_o.valid = 1'b1;
          res_o.kind  = cdf_pkg::KIND_DISCARD;
        end
        key_cnt_d = 4'd0;
        end_d     = cdf_pkg::END_IDLE;
        phase_d   = cdf_pkg::PH_KEY;
        seen_d    = 1'b0;
        len_d     = '0;
        over_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      key_cnt_q    <= 4'd0;
      end_q        <= cdf_pkg::END_IDLE;
      phase_q      <= cdf_pkg::PH_KEY;
      seen_q       <= 1'b0;
      len_q        <= '0;
      over_q       <= 1'b0;
      rem_q        <= '0;
      max_len_q    <= '1;
    end else begin
      if (step_i) begin
        in_payload_q <= in_payload_d;
        key_cnt_q    <= key_cnt_d;
        end_q        <= end_d;
        phase_q      <= phase_d;
        seen_q       <= seen_d;
        len_q        <= len_d;
        over_q       <= over_d;
        rem_q        <= rem_d;
      end
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ hw/rtl/cdf_out_stage.sv @@
module cdf_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          stage_valid_i,
  input  cdf_pkg::res_t res_i,
  input  logic          out_ready_i,
  output logic          take_o,
  output logic          out_valid_o,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_payload_byte_o,
  output logic          out_last_byte_o
);

  logic                  valid_q, valid_d;
  cdf_pkg::kind_e        kind_q;
  logic [7:0]            payload_byte_q;
  logic                  last_byte_q;

  // A byte leaves the input stage whenever the result register is free or being emptied.
  assign take_o = stage_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (take_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_i.valid) begin
      kind_q         <= res_i.kind;
      payload_byte_q <= res_i.payload_byte;
      last_byte_q    <= res_i.last_byte;
    end
  end

  assign out_valid_o        = valid_q;
  assign out_kind_o         = kind_q;
  assign out_payload_byte_o = payload_byte_q;
  assign out_last_byte_o    = last_byte_q;

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [31:0] LEN_ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    cdf_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } deframed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cdf_byte_if   byte_bus ();
  cdf_result_if res_bus ();
  cdf_cfg_if    cfg_bus ();

  content_length_stream_deframer_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_bus),
    .out_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always #5 clk = ~clk;

  // Shadow copy of the deframer state.
  logic [31:0]         max_len;
  bit                  pl_active;
  logic [31:0]         pl_left;
  int unsigned         key_pos;
  cdf_pkg::phase_e     num_phase;
  cdf_pkg::end_state_e crlf_state;
  bit                  got_digit;
  longint unsigned     len_acc;
  bit                  len_over;

  deframed_t   due_results[$];
  logic [7:0]  frame[$];
  int          fail_count;
  int          bytes_sent;
  int          hold_left;
  int          burst_left;
  bit          gaps_on;
  int unsigned cycle_count;

  function automatic void expect_result(input cdf_pkg::kind_e k, input logic [7:0] d,
                                        input logic l);
    deframed_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    frame.insert(frame.size(), b);
  endfunction

  function automatic void restart_header();
    key_pos    = 0;
    num_phase  = cdf_pkg::PH_KEY;
    crlf_state = cdf_pkg::END_IDLE;
    got_digit  = 1'b0;
    len_acc    = 0;
    len_over   = 1'b0;
  endfunction

  function automatic void deframe_step(input logic [7:0] b);
    longint unsigned dgt;
    bit              hdr_end;
    if (pl_active) begin
      pl_left = pl_left - 1;
      expect_result(cdf_pkg::KIND_PAYLOAD, b, pl_left == 0);
      if (pl_left == 0) begin
        pl_active = 1'b0;
      end
      return;
    end
    case (num_phase)
      cdf_pkg::PH_KEY: begin
        if (key_pos < cdf_pkg::KEY_LEN && b == cdf_pkg::KEY_TEXT[key_pos]) begin
          key_pos++;
        end else begin
          key_pos = (b == cdf_pkg::KEY_TEXT[0]) ? 1 : 0;
        end
        if (key_pos >= cdf_pkg::KEY_LEN) begin
          num_phase = cdf_pkg::PH_BLANK;
          key_pos   = 0;
        end
      end
      cdf_pkg::PH_BLANK, cdf_pkg::PH_DIGITS: begin
        if (!(num_phase == cdf_pkg::PH_BLANK &&
              (b == cdf_pkg::CHAR_SPACE || b == cdf_pkg::CHAR_TAB))) begin
          if (b >= cdf_pkg::CHAR_ZERO && b <= cdf_pkg::CHAR_NINE) begin
            dgt       = longint'(b - cdf_pkg::CHAR_ZERO);
            num_phase = cdf_pkg::PH_DIGITS;
            got_digit = 1'b1;
            if (!len_over) begin
              if (len_acc > (longint'(LEN_ALL_ONES) - dgt) / 10) begin
                len_over = 1'b1;
              end else begin
                len_acc = len_acc * 10 + dgt;
              end
            end
          end else begin
            num_phase = cdf_pkg::PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
    // The terminator byte has already passed the key and number scan above.
    hdr_end = 1'b0;
    if (b == cdf_pkg::CHAR_CR) begin
      crlf_state = (crlf_state == cdf_pkg::END_CRLF) ? cdf_pkg::END_CRLFCR : cdf_pkg::END_CR;
    end else if (b == cdf_pkg::CHAR_LF && crlf_state == cdf_pkg::END_CRLFCR) begin
      hdr_end = 1'b1;
    end else if (b == cdf_pkg::CHAR_LF && crlf_state == cdf_pkg::END_CR) begin
      crlf_state = cdf_pkg::END_CRLF;
    end else begin
      crlf_state = cdf_pkg::END_IDLE;
    end
    if (hdr_end) begin
      if (got_digit && !len_over && len_acc <= longint'(max_len)) begin
        if (len_acc == 0) begin
          expect_result(cdf_pkg::KIND_EMPTY, 8'h00, 1'b0);
        end else begin
          pl_active = 1'b1;
          pl_left   = len_acc[31:0];
        end
      end else begin
        expect_result(cdf_pkg::KIND_DISCARD, 8'h00, 1'b0);
      end
      restart_header();
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    deframed_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d byte %02h last %0b",
                 $time, res_bus.kind, res_bus.payload_byte, res_bus.last_byte);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (res_bus.kind !== want.kind || res_bus.payload_byte !== want.data ||
            res_bus.last_byte !== want.last) begin
          $display("%0t: result mismatch: expected kind %0d byte %02h last %0b, %s",
                   $time, want.kind, want.data, want.last,
                   $sformatf("got kind %0d byte %02h last %0b",
                             res_bus.kind, res_bus.payload_byte, res_bus.last_byte));
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result receiver: a long hold-off when asked, otherwise short random stalls while gaps are on.
  initial begin
    res_bus.ready = 1'b0;
    burst_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        res_bus.ready = 1'b0;
        burst_left--;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        res_bus.ready = 1'b0;
        burst_left    = $urandom_range(0, 8);
      end else begin
        res_bus.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      byte_bus.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    byte_bus.valid       = 1'b1;
    byte_bus.stream_byte = b;
    do @(posedge clk); while (!byte_bus.ready);
    deframe_step(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame[i]) begin
      send_byte(frame[i]);
    end
    frame.delete();
  endtask

  task automatic send_payload(input int cut);
    int k;
    k = 0;
    while (pl_active && k < cut) begin
      send_byte(8'($urandom_range(0, 255)));
      k++;
    end
  endtask

  task automatic wait_for_results();
    byte_bus.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    // Header bytes give no result, so let the pipeline settle as well.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] v);
    wait_for_results();
    cfg_bus.valid      = 1'b1;
    cfg_bus.max_length = v;
    do @(posedge clk); while (!cfg_bus.ready);
    max_len = v;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(s[i]);
    end
  endfunction

  function automatic void add_crlf();
    put_byte(cdf_pkg::CHAR_CR);
    put_byte(cdf_pkg::CHAR_LF);
  endfunction

  function automatic void add_key(input int n);
    for (int i = 0; i < n; i++) begin
      put_byte(cdf_pkg::KEY_TEXT[i]);
    end
  endfunction

  function automatic void add_header(input string digits);
    add_key(cdf_pkg::KEY_LEN);
    add_text(digits);
    add_crlf();
    add_crlf();
  endfunction

  task automatic test_directed_frames();
    gaps_on = 1'b0;
    add_header("0");
    add_key(cdf_pkg::KEY_LEN);
    put_byte(cdf_pkg::CHAR_SPACE);
    put_byte(cdf_pkg::CHAR_TAB);
    add_header("");
    send_frame();
    // Blanks before the digits, then payload bytes at both extremes.
    add_key(cdf_pkg::KEY_LEN);
    put_byte(cdf_pkg::CHAR_SPACE);
    put_byte(cdf_pkg::CHAR_TAB);
    add_text("2");
    add_crlf();
    add_crlf();
    put_byte(8'h00);
    put_byte(8'hFF);
    add_header("");
    // A broken key, then the key twice; only the first occurrence counts.
    add_key(11);
    add_key(cdf_pkg::KEY_LEN);
    add_text("1 ");
    add_header("7");
    put_byte(8'h5A);
    add_header("x5");
    add_header("4294967296");
    put_byte(cdf_pkg::CHAR_CR);
    add_crlf();
    add_crlf();
    add_key(cdf_pkg::KEY_LEN);
    add_text("0003");
    add_crlf();
    add_text("A: b");
    add_crlf();
    add_crlf();
    add_text("xyz");
    send_frame();
    // A header cut short gives nothing until the rest arrives.
    add_key(cdf_pkg::KEY_LEN);
    add_text("1");
    send_frame();
    wait_for_results();
    add_crlf();
    add_crlf();
    put_byte(8'h80);
    send_frame();
    wait_for_results();
  endtask

  task automatic test_length_limits();
    gaps_on = 1'b1;
    write_max_length(32'd0);
    add_header("0");
    add_header("1");
    send_frame();
    write_max_length(32'd5);
    add_header("5");
    send_frame();
    send_payload(5);
    add_header("6");
    send_frame();
    write_max_length(LEN_ALL_ONES - 1);
    add_header("4294967295");
    add_header("3");
    send_frame();
    send_payload(3);
    write_max_length(LEN_ALL_ONES);
    add_header("4294967296");
    add_header("2");
    send_frame();
    send_payload(2);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    wait_for_results();
    gaps_on   = 1'b0;
    hold_left = 80;
    add_header("40");
    send_frame();
    send_payload(40);
    add_header("0");
    send_frame();
    wait_for_results();
  endtask

  task automatic send_random_message();
    int              pick;
    int              n;
    longint unsigned v;
    frame.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        add_crlf();
      end
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      add_key($urandom_range(1, cdf_pkg::KEY_LEN - 1));
    end
    if (pick != 1) begin
      add_key(cdf_pkg::KEY_LEN);
    end
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
      put_byte($urandom_range(0, 1) ? cdf_pkg::CHAR_SPACE : cdf_pkg::CHAR_TAB);
    end
    if ($urandom_range(0, 9) == 0) begin
      add_text("00");
    end
    pick = $urandom_range(0, 19);
    case (pick)
      0: add_text("x");
      1: begin
        n = $urandom_range(11, 20);
        for (int i = 0; i < n; i++) begin
          put_byte(8'(cdf_pkg::CHAR_ZERO + $urandom_range(i == 0 ? 1 : 0, 9)));
        end
      end
      2: add_text("4294967296");
      3: begin
        v = (max_len != LEN_ALL_ONES) ? longint'(max_len) + 1 + $urandom_range(0, 3)
                                      : 64'd4294967296;
        add_text($sformatf("%0d", v));
      end
      4: add_text($sformatf("%0d", (max_len <= 64) ? max_len : $urandom_range(1, 12)));
      5, 6: add_text($sformatf("%0d", $urandom_range(20, 64)));
      7: add_text("0");
      default: add_text($sformatf("%0d", $urandom_range(1, 12)));
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      add_text(" ");
      add_key(cdf_pkg::KEY_LEN);
      add_text($sformatf("%0d", $urandom_range(0, 99)));
    end else if (pick == 1) begin
      add_crlf();
      repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
    end
    add_crlf();
    add_crlf();
    if ($urandom_range(0, 24) == 0) begin
      frame = frame[0:$urandom_range(0, frame.size() - 1)];
    end
    send_frame();
    send_payload($urandom_range(0, 24) == 0 ? $urandom_range(0, 8) : 1000);
  endtask

  task automatic test_random_frames(input int byte_target);
    int pick;
    while (bytes_sent < byte_target) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, 39);
      if (pick == 0) begin
        pick = $urandom_range(0, 4);
        write_max_length(pick == 0 ? 32'd0 :
                         pick == 1 ? 32'($urandom_range(1, 64)) :
                         pick == 2 ? 32'($urandom) : LEN_ALL_ONES);
      end else if (pick == 1) begin
        // Sender stops until every outstanding transaction has come back.
        wait_for_results();
      end
      send_random_message();
    end
    wait_for_results();
  endtask

  task automatic test_steady_stream(input int byte_target);
    write_max_length(LEN_ALL_ONES);
    gaps_on = 1'b0;
    while (bytes_sent < byte_target) begin
      send_random_message();
    end
  endtask

  initial begin
    byte_bus.valid       = 1'b0;
    byte_bus.stream_byte = 8'h00;
    cfg_bus.valid        = 1'b0;
    cfg_bus.max_length   = '0;
    bytes_sent           = 0;
    hold_left            = 0;
    gaps_on              = 1'b0;
    max_len              = LEN_ALL_ONES;
    pl_active            = 1'b0;
    pl_left              = '0;
    restart_header();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_length_limits();
    test_backpressure();
    test_random_frames(1500);
    test_steady_stream(1750);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cdf_pkg.sv
hw/rtl/cdf_if.sv
hw/rtl/cdf_in_stage.sv
hw/rtl/cdf_parser.sv
hw/rtl/cdf_out_stage.sv
hw/rtl/content_length_stream_deframer_core.sv
dv/testbench.sv
